>>> rtl/stfr_pkg.sv
// Shared types, constants and register codes of the telemetry frame receiver.
package stfr_pkg;

  localparam int PAYLOAD_LEN = 22;
  localparam int KEPT_LEN    = 20;
  localparam int N_MOTION    = 6;
  localparam int N_ACCEL     = 3;
  localparam int IDX_W       = 5;

  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 4;

  localparam logic [7:0] SYNC_A = 8'hFF;
  localparam logic [7:0] SYNC_B = 8'hFE;
  localparam logic [7:0] SYNC_C = 8'hFD;
  localparam logic [7:0] SYNC_D = 8'hFC;

  localparam logic [15:0] ACCEL_GAIN_RST     = 16'd266;
  localparam logic [15:0] GYRO_GAIN_RST      = 16'd1022;
  localparam logic [15:0] BATTERY_GAIN_RST   = 16'd164;
  localparam logic [23:0] BATTERY_OFFSET_RST = 24'd655360;

  localparam logic KIND_LOST   = 1'b0;
  localparam logic KIND_PACKET = 1'b1;

  typedef enum logic [1:0] {
    REG_ACCEL_GAIN     = 2'd0,
    REG_GYRO_GAIN      = 2'd1,
    REG_BATTERY_GAIN   = 2'd2,
    REG_BATTERY_OFFSET = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] accel_gain;
    logic [15:0] gyro_gain;
    logic [15:0] battery_gain;
    logic [23:0] battery_offset;
  } cfg_t;

  // Request handed from the framer to the decoder: payload bytes 0..19.
  typedef struct packed {
    logic                     kind;
    logic [KEPT_LEN-1:0][7:0] bytes;
  } frame_t;

  typedef struct packed {
    logic                      kind;
    logic [31:0]               packet_time;
    logic [N_MOTION-1:0][31:0] motion;
    logic [15:0]               altitude_raw;
    logic [31:0]               battery_volts;
    logic [N_MOTION-1:0]       invalid_mask;
  } result_t;

endpackage

>>> rtl/stfr_fifo.sv
// Small register-based first-in first-out queue.
module stfr_fifo #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt;
  logic [AW-1:0]    rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == CW'(DEPTH));
  assign count   = cnt_r;
  assign rdata   = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

>>> rtl/stfr_front.sv
// Framer: sync word hunt, payload capture and frame acceptance.
module stfr_front
  import stfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] rx_byte,
  output logic       emit,
  output frame_t     frame
);

  typedef enum logic [8:0] {
    ST_HUNT    = 9'b000000001,
    ST_GOT_A   = 9'b000000010,
    ST_GOT_B   = 9'b000000100,
    ST_GOT_C   = 9'b000001000,
    ST_PAYLOAD = 9'b000010000,
    ST_TRAIL_A = 9'b000100000,
    ST_TRAIL_B = 9'b001000000,
    ST_TRAIL_C = 9'b010000000,
    ST_TRAIL_D = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       store_r [PAYLOAD_LEN];
  logic             store_we;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    store_we    = 1'b0;
    emit        = 1'b0;
    frame.kind  = KIND_LOST;
    frame.bytes = '0;
    if (take) begin
      unique case (state_r)
        ST_GOT_A: begin
          if (rx_byte == SYNC_B) begin
            state_nxt = ST_GOT_B;
          end else if (rx_byte != SYNC_A) begin
            state_nxt = ST_HUNT;
          end
        end
        ST_GOT_B: state_nxt = (rx_byte == SYNC_C) ? ST_GOT_C : ST_HUNT;
        ST_GOT_C: state_nxt = (rx_byte == SYNC_D) ? ST_PAYLOAD : ST_HUNT;
        ST_PAYLOAD: begin
          if (idx_r < IDX_W'(PAYLOAD_LEN)) begin
            store_we = 1'b1;
            idx_nxt  = idx_r + 1'b1;
          end
          if (idx_nxt >= IDX_W'(PAYLOAD_LEN)) begin
            state_nxt = ST_TRAIL_A;
          end
        end
        ST_TRAIL_A: begin
          state_nxt = (rx_byte == SYNC_A) ? ST_TRAIL_B : ST_HUNT;
          if (rx_byte != SYNC_A) idx_nxt = '0;
        end
        ST_TRAIL_B: begin
          state_nxt = (rx_byte == SYNC_B) ? ST_TRAIL_C : ST_HUNT;
          if (rx_byte != SYNC_B) idx_nxt = '0;
        end
        ST_TRAIL_C: begin
          state_nxt = (rx_byte == SYNC_C) ? ST_TRAIL_D : ST_HUNT;
          if (rx_byte != SYNC_C) idx_nxt = '0;
        end
        ST_TRAIL_D: begin
          idx_nxt = '0;
          if (rx_byte == SYNC_D) begin
            // Trailing sync closes this frame and opens the next payload.
            emit       = 1'b1;
            frame.kind = KIND_PACKET;
            for (int k = 0; k < KEPT_LEN; k++) begin
              frame.bytes[k] = store_r[k];
            end
            state_nxt = ST_PAYLOAD;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
        default: begin
          // Hunting: every byte reports lost sync.
          emit      = 1'b1;
          idx_nxt   = '0;
          state_nxt = (rx_byte == SYNC_A) ? ST_GOT_A : ST_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_HUNT;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_r[idx_r] <= rx_byte;
    end
  end

endmodule

>>> rtl/stfr_back.sv
// Decoder: scales motion words and battery reading, holds last valid motion.
module stfr_back
  import stfr_pkg::*;
#(
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfg_t                           cfg,
  input  frame_t                         head,
  input  logic                           head_valid,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           head_pop,
  output logic                           res_valid,
  output result_t                        res
);

  localparam int OCW = $clog2(OUT_DEPTH + 1);

  logic [OCW+1:0] occupancy;

  // Stage A: products.
  logic                      a_valid_r;
  logic                      a_kind_r;
  logic [31:0]               a_time_r;
  logic [N_MOTION-1:0][31:0] a_prod_r, a_prod_nxt;
  logic [N_MOTION-1:0]       a_inv_r, a_inv_nxt;
  logic [15:0]               a_alt_r;
  logic [31:0]               a_bprod_r;

  // Stage B: result and held motion.
  logic                      b_valid_r;
  result_t                   b_res_r, b_res_nxt;
  logic [N_MOTION-1:0][31:0] held_r, held_nxt;
  logic [32:0]               batt_sum;

  // Count every result already in flight against the output queue.
  assign occupancy = (OCW+2)'(out_count) + (OCW+2)'(a_valid_r) + (OCW+2)'(b_valid_r);
  assign head_pop  = head_valid && (occupancy < (OCW+2)'(OUT_DEPTH));

  always_comb begin
    logic [15:0]        raw;
    logic signed [14:0] v;
    logic [15:0]        g;
    logic signed [17:0] gm;
    logic signed [32:0] p;
    for (int k = 0; k < N_MOTION; k++) begin
      raw = {head.bytes[4 + 2*k], head.bytes[5 + 2*k]};
      v   = signed'(raw[14:0]);
      g   = (k < N_ACCEL) ? cfg.accel_gain : cfg.gyro_gain;
      gm  = signed'({1'b0, g, 1'b0});
      p   = v * gm;
      a_prod_nxt[k] = p[31:0];
      a_inv_nxt[k]  = raw[15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= head_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      a_kind_r  <= head.kind;
      a_time_r  <= {head.bytes[0], head.bytes[1], head.bytes[2], head.bytes[3]};
      a_prod_r  <= a_prod_nxt;
      a_inv_r   <= a_inv_nxt;
      a_alt_r   <= {head.bytes[16], head.bytes[17]};
      a_bprod_r <= 32'(cfg.battery_gain) * 32'({head.bytes[18], head.bytes[19]});
    end
  end

  assign batt_sum = {1'b0, a_bprod_r} + {9'd0, cfg.battery_offset};

  always_comb begin
    held_nxt  = held_r;
    b_res_nxt = '0;
    if (a_valid_r && (a_kind_r == KIND_PACKET)) begin
      b_res_nxt.kind         = KIND_PACKET;
      b_res_nxt.packet_time  = a_time_r;
      b_res_nxt.altitude_raw = a_alt_r;
      b_res_nxt.invalid_mask = a_inv_r;
      // Saturate the battery sum at all ones.
      b_res_nxt.battery_volts = batt_sum[32] ? '1 : batt_sum[31:0];
      for (int k = 0; k < N_MOTION; k++) begin
        held_nxt[k] = a_inv_r[k] ? held_r[k] : a_prod_r[k];
      end
      b_res_nxt.motion = held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      held_r    <= '0;
    end else begin
      b_valid_r <= a_valid_r;
      held_r    <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      b_res_r <= b_res_nxt;
    end
  end

  assign res_valid = b_valid_r;
  assign res       = b_res_r;

endmodule

>>> rtl/sync_framed_telemetry_receiver.sv
// Top level of the sync-framed telemetry receiver: framer, request queue, decoder, result queue.
//
// Usage:
//   Input channel: drive in_rx_byte with push; a byte is taken at a clock edge with
//   push high and full low. Bytes may be pushed on every cycle.
//   Result channel: while empty is low the oldest result sits on the out_* ports;
//   pop takes it. A lost-sync result (out_kind 0, all other fields zero) comes for
//   every byte seen while hunting for the first sync byte; a packet result
//   (out_kind 1) comes when a 22-byte payload is closed by a trailing sync word.
//   Path: request queue, decoder stage A, decoder stage B, result queue.
//   Throughput: one byte per cycle, limited only by the 1-per-cycle decoder pipe
//   and result queue; with pop held high the block never raises full.
//   Stall: when pop stays low the result queue fills, the decoder holds, the
//   request queue fills and full rises; nothing is dropped.
//   Reset (rst_n low, synchronous): framer back to hunting, queues emptied, held
//   motion values cleared and gain and offset registers back to their defaults.
//   Configuration: APB registers accel_gain (0x0), gyro_gain (0x4),
//   battery_gain (0x8), battery_offset (0xC); write only while idle.
module sync_framed_telemetry_receiver
  import stfr_pkg::*;
#(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  // Result channel
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [31:0] out_packet_time,
  output logic signed [31:0] out_accel_x,
  output logic signed [31:0] out_accel_y,
  output logic signed [31:0] out_accel_z,
  output logic signed [31:0] out_rate_roll,
  output logic signed [31:0] out_rate_pitch,
  output logic signed [31:0] out_rate_yaw,
  output logic [15:0] out_altitude_raw,
  output logic [31:0] out_battery_volts,
  output logic [5:0]  out_invalid_mask,
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;

  logic     take;
  logic     front_emit;
  frame_t   front_frame;
  frame_t   mid_head;
  logic     mid_empty;
  logic     mid_pop;

  logic                           res_valid;
  result_t                        res;
  result_t                        out_head;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;

  // Configuration registers: one per word, always ready.
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accel_gain     <= ACCEL_GAIN_RST;
      cfg_r.gyro_gain      <= GYRO_GAIN_RST;
      cfg_r.battery_gain   <= BATTERY_GAIN_RST;
      cfg_r.battery_offset <= BATTERY_OFFSET_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ACCEL_GAIN:     cfg_r.accel_gain     <= pwdata[15:0];
        REG_GYRO_GAIN:      cfg_r.gyro_gain      <= pwdata[15:0];
        REG_BATTERY_GAIN:   cfg_r.battery_gain   <= pwdata[15:0];
        REG_BATTERY_OFFSET: cfg_r.battery_offset <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACCEL_GAIN:     prdata = {16'd0, cfg_r.accel_gain};
      REG_GYRO_GAIN:      prdata = {16'd0, cfg_r.gyro_gain};
      REG_BATTERY_GAIN:   prdata = {16'd0, cfg_r.battery_gain};
      REG_BATTERY_OFFSET: prdata = {8'd0, cfg_r.battery_offset};
      default:            prdata = '0;
    endcase
  end

  // Front: take a byte whenever the request queue has room for its request.
  assign take = push && !full;

  stfr_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_rx_byte),
    .emit    (front_emit),
    .frame   (front_frame)
  );

  stfr_fifo #(
    .DEPTH (MID_DEPTH),
    .WIDTH ($bits(frame_t))
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_emit),
    .wdata (front_frame),
    .pop   (mid_pop),
    .rdata (mid_head),
    .empty (mid_empty),
    .full  (full),
    .count ()
  );

  // Back: decode one request per cycle while the result queue has credit.
  stfr_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (mid_head),
    .head_valid (!mid_empty),
    .out_count  (out_count),
    .head_pop   (mid_pop),
    .res_valid  (res_valid),
    .res        (res)
  );

  // Credit in the decoder keeps the result queue from overflowing, so its full
  // flag is left open.
  stfr_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH ($bits(result_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .pop   (pop),
    .rdata (out_head),
    .empty (empty),
    .full  (),
    .count (out_count)
  );

  assign out_kind          = out_head.kind;
  assign out_packet_time   = out_head.packet_time;
  assign out_accel_x       = out_head.motion[0];
  assign out_accel_y       = out_head.motion[1];
  assign out_accel_z       = out_head.motion[2];
  assign out_rate_roll     = out_head.motion[3];
  assign out_rate_pitch    = out_head.motion[4];
  assign out_rate_yaw      = out_head.motion[5];
  assign out_altitude_raw  = out_head.altitude_raw;
  assign out_battery_volts = out_head.battery_volts;
  assign out_invalid_mask  = out_head.invalid_mask;

endmodule
